/* hdl/i2cm_pkg.sv */
// Shared types, codes and constants of the I2C master bit engine.
package i2cm_pkg;

  localparam int CNT_W  = 16;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [1:0] CFG_BIT_DELAY   = 2'd0;
  localparam logic [1:0] CFG_EDGE_DELAY  = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [CNT_W-1:0] BIT_DELAY_RST   = CNT_W'(5);
  localparam logic [CNT_W-1:0] EDGE_DELAY_RST  = CNT_W'(2);
  localparam logic [CNT_W-1:0] ACK_TIMEOUT_RST = CNT_W'(12'hFFF);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    RK_TICK,
    RK_START,
    RK_STOP,
    RK_WRITE,
    RK_READ,
    RK_NOP
  } req_kind_t;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] data;
    logic       ack;
    logic       sda;
  } req_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START1,
    PH_START2,
    PH_STOP1,
    PH_STOP2,
    PH_STOP3,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_ACK_LOW,
    PH_ACK_WAIT,
    PH_ACK_HIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_MA1,
    PH_MA2,
    PH_MN1,
    PH_MN2,
    PH_MN3
  } phase_t;

endpackage

/* hdl/i2cm_front.sv */
// Front end: accepts input items and classifies them into requests.
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output req_t     q_req
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_req.data = in_data.write_data;
    q_req.ack  = in_data.send_ack;
    q_req.sda  = in_data.sda_in;
    unique case (in_data.operation)
      OP_TICK:              q_req.kind = RK_TICK;
      OP_START, OP_RESTART: q_req.kind = RK_START;
      OP_STOP:              q_req.kind = RK_STOP;
      OP_WRITE:             q_req.kind = RK_WRITE;
      OP_READ:              q_req.kind = RK_READ;
      default:              q_req.kind = RK_NOP;
    endcase
  end

endmodule

/* hdl/i2cm_queue.sv */
// Short request queue between the front end and the bus sequencer.
module i2cm_queue
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output req_t pop_req
);

  req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_req   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

/* hdl/i2cm_back.sv */
// Bus sequencer: executes requests, holds timing registers and the result register.
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             q_not_empty,
  input  req_t             q_req,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  logic [CNT_W-1:0] bit_delay_r, edge_delay_r, ack_timeout_r;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] delay_r, delay_nxt;
  logic [CNT_W-1:0] wait_r, wait_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       rx_hold_r, rx_hold_nxt;
  logic             ack_sel_r, ack_sel_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             oe_r, oe_nxt;
  logic             timed_out_r, timed_out_nxt;
  logic             done;
  logic [1:0]       status;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic             go, idle, expire, last_bit;
  logic [3:0]       bc_inc;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign go        = q_pop;
  assign idle      = (phase_r == PH_IDLE);
  assign expire    = !idle && (phase_r != PH_ACK_WAIT) && (delay_r <= CNT_W'(1));
  assign bc_inc    = bit_cnt_r + 4'd1;
  assign last_bit  = bc_inc[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r   <= BIT_DELAY_RST;
      edge_delay_r  <= EDGE_DELAY_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BIT_DELAY:   bit_delay_r   <= cfg_data;
        CFG_EDGE_DELAY:  edge_delay_r  <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      unique case (q_req.kind)
        RK_TICK: begin
          if (phase_r == PH_ACK_WAIT) begin
            if (!q_req.sda) begin
              phase_nxt = PH_ACK_HIGH;
            end else if (wait_r == '0) begin
              phase_nxt = PH_STOP1;
            end
          end else if (expire) begin
            unique case (phase_r)
              PH_START1:  phase_nxt = PH_START2;
              PH_STOP1:   phase_nxt = PH_STOP2;
              PH_STOP2:   phase_nxt = PH_STOP3;
              PH_WR_LOW:  phase_nxt = PH_WR_HIGH;
              PH_WR_HIGH: phase_nxt = last_bit ? PH_ACK_LOW : PH_WR_LOW;
              PH_ACK_LOW: phase_nxt = PH_ACK_WAIT;
              PH_RD_LOW:  phase_nxt = PH_RD_HIGH;
              PH_RD_HIGH: begin
                if (last_bit) begin
                  phase_nxt = ack_sel_r ? PH_MA1 : PH_MN1;
                end else begin
                  phase_nxt = PH_RD_LOW;
                end
              end
              PH_MA1:     phase_nxt = PH_MA2;
              PH_MN1:     phase_nxt = PH_MN2;
              PH_MN2:     phase_nxt = PH_MN3;
              default:    phase_nxt = PH_IDLE;
            endcase
          end
        end
        RK_START: if (idle) phase_nxt = PH_START1;
        RK_STOP:  if (idle) phase_nxt = PH_STOP1;
        RK_WRITE: if (idle) phase_nxt = PH_WR_LOW;
        RK_READ:  if (idle) phase_nxt = PH_RD_LOW;
        RK_NOP: ;
        default: ;
      endcase
    end
  end

  // pins, counters and result fields
  always_comb begin
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    oe_nxt        = oe_r;
    delay_nxt     = delay_r;
    wait_nxt      = wait_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    rx_hold_nxt   = rx_hold_r;
    ack_sel_nxt   = ack_sel_r;
    timed_out_nxt = timed_out_r;
    done          = 1'b0;
    status        = ST_OK;
    if (go) begin
      unique case (q_req.kind)
        RK_TICK: begin
          if (phase_r == PH_ACK_WAIT) begin
            if (!q_req.sda) begin
              delay_nxt = bit_delay_r;
            end else if (wait_r == '0) begin
              timed_out_nxt = 1'b1;
              scl_nxt       = 1'b0;
              sda_nxt       = 1'b0;
              oe_nxt        = 1'b1;
              delay_nxt     = edge_delay_r;
            end else begin
              wait_nxt = wait_r - CNT_W'(1);
            end
          end else if (!idle && !expire) begin
            delay_nxt = delay_r - CNT_W'(1);
          end else if (expire) begin
            unique case (phase_r)
              PH_START1: begin
                sda_nxt   = 1'b0;
                delay_nxt = edge_delay_r;
              end
              PH_START2: begin
                scl_nxt = 1'b0;
                done    = 1'b1;
              end
              PH_STOP1: begin
                scl_nxt   = 1'b1;
                delay_nxt = edge_delay_r;
              end
              PH_STOP2: begin
                sda_nxt   = 1'b1;
                delay_nxt = edge_delay_r;
              end
              PH_STOP3: done = 1'b1;
              PH_WR_LOW: begin
                sda_nxt   = shift_r[7];
                scl_nxt   = 1'b1;
                delay_nxt = bit_delay_r;
              end
              PH_WR_HIGH: begin
                shift_nxt   = {shift_r[6:0], 1'b0};
                bit_cnt_nxt = bc_inc;
                scl_nxt     = 1'b0;
                delay_nxt   = bit_delay_r;
                if (last_bit) begin
                  oe_nxt = 1'b0;
                end
              end
              PH_ACK_LOW: begin
                scl_nxt  = 1'b1;
                wait_nxt = ack_timeout_r;
              end
              PH_ACK_HIGH: begin
                scl_nxt = 1'b0;
                sda_nxt = 1'b1;
                oe_nxt  = 1'b1;
                done    = 1'b1;
              end
              PH_RD_LOW: begin
                scl_nxt   = 1'b1;
                shift_nxt = {shift_r[6:0], q_req.sda};
                delay_nxt = bit_delay_r;
              end
              PH_RD_HIGH: begin
                bit_cnt_nxt = bc_inc;
                scl_nxt     = 1'b0;
                delay_nxt   = bit_delay_r;
                if (last_bit) begin
                  rx_hold_nxt = shift_r;
                  oe_nxt      = 1'b1;
                  sda_nxt     = 1'b0;
                end
              end
              PH_MA1: begin
                scl_nxt   = 1'b1;
                delay_nxt = bit_delay_r;
              end
              PH_MA2: begin
                scl_nxt = 1'b0;
                done    = 1'b1;
              end
              PH_MN1: begin
                sda_nxt   = 1'b1;
                delay_nxt = bit_delay_r;
              end
              PH_MN2: begin
                scl_nxt   = 1'b1;
                delay_nxt = bit_delay_r;
              end
              PH_MN3: begin
                scl_nxt = 1'b0;
                done    = 1'b1;
              end
              default: ;
            endcase
            if (done && timed_out_r) begin
              status        = ST_TIMEOUT;
              timed_out_nxt = 1'b0;
            end
          end
        end
        RK_START: begin
          if (!idle) begin
            status = ST_BUSY;
          end else begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            oe_nxt    = 1'b1;
            delay_nxt = edge_delay_r;
          end
        end
        RK_STOP: begin
          if (!idle) begin
            status = ST_BUSY;
          end else begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            oe_nxt    = 1'b1;
            delay_nxt = edge_delay_r;
          end
        end
        RK_WRITE: begin
          if (!idle) begin
            status = ST_BUSY;
          end else begin
            shift_nxt   = q_req.data;
            bit_cnt_nxt = '0;
            scl_nxt     = 1'b0;
            oe_nxt      = 1'b1;
            delay_nxt   = bit_delay_r;
          end
        end
        RK_READ: begin
          if (!idle) begin
            status = ST_BUSY;
          end else begin
            shift_nxt   = '0;
            bit_cnt_nxt = '0;
            ack_sel_nxt = q_req.ack;
            oe_nxt      = 1'b0;
            scl_nxt     = 1'b0;
            delay_nxt   = bit_delay_r;
          end
        end
        RK_NOP: ;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = go || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      delay_r     <= '0;
      wait_r      <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      rx_hold_r   <= '0;
      ack_sel_r   <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      oe_r        <= 1'b1;
      timed_out_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      wait_r      <= wait_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      rx_hold_r   <= rx_hold_nxt;
      ack_sel_r   <= ack_sel_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      oe_r        <= oe_nxt;
      timed_out_r <= timed_out_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r.scl_level <= scl_nxt;
      out_data_r.sda_level <= sda_nxt;
      out_data_r.sda_drive <= oe_nxt;
      out_data_r.busy_res  <= (phase_nxt != PH_IDLE);
      out_data_r.done_res  <= done;
      out_data_r.read_data <= rx_hold_nxt;
      out_data_r.status    <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done result reports busy");

  a_timeout_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_TIMEOUT) |-> out_data_r.done_res)
    else $error("timeout status without done");

  a_ack_wait_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ACK_WAIT) |-> !oe_r)
    else $error("SDA driven while waiting for ACK");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r[3] |-> (bit_cnt_r[2:0] == 3'd0))
    else $error("bit count beyond eight");

  a_timeout_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
    timed_out_r |-> (phase_r == PH_STOP1) || (phase_r == PH_STOP2) || (phase_r == PH_STOP3))
    else $error("timeout pending outside stop sequence");

endmodule

/* hdl/i2c_master_bit_engine.sv */
// I2C master bit engine: sustains one item per clock cycle while the result is
// taken. An accepted item is decoded and placed in a two-entry request queue; the
// bus sequencer takes one request per cycle from the queue, unless its result
// register is stalled, and registers its result. Every item, tick or command,
// gives exactly one result. The rate is set by the sequencer step; a stalled result
// register holds the sequencer, and the queue absorbs up to two further items before
// in_ready drops. Timing registers must be written through the cfg port only while
// no items are in flight; the block does not enforce this. cfg_ready is always high.
module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  logic q_full, q_push, q_pop, q_not_empty;
  req_t push_req, pop_req;

  i2cm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (push_req)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (push_req),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_req   (pop_req)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_req       (pop_req),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
